// File: sv/consensus_unstable_log_table_unit_macros.svh
// Assertion macros used by the checker file of the unstable log table.
`ifndef CONSENSUS_UNSTABLE_LOG_TABLE_UNIT_MACROS_SVH
`define CONSENSUS_UNSTABLE_LOG_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CULOG_CHECK_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("unstable log table check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CULOG_CHECK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("unstable log table check failed");

`endif

// File: sv/culog_pkg.sv
// Package with the types, widths and codes of the unstable log table.
`default_nettype none
package culog_pkg;

  // Ring depth and derived widths.
  localparam int unsigned LOG_DEPTH = 256;
  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);

  // Operation codes.
  localparam logic [2:0] MODE_APPEND       = 3'd0;
  localparam logic [2:0] MODE_LOOKUP       = 3'd1;
  localparam logic [2:0] MODE_STABLE_TO    = 3'd2;
  localparam logic [2:0] MODE_STABLE_SNAP  = 3'd3;
  localparam logic [2:0] MODE_RESTORE_SNAP = 3'd4;

  // Status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_GAP  = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] entry_index;
    logic [63:0] entry_term;
  } req_t;

  typedef struct packed {
    logic [63:0] term;
    logic        found;
    logic [1:0]  status;
    logic [63:0] first_index;
    logic        first_valid;
    logic [63:0] last_index;
    logic        last_valid;
  } rsp_t;

  typedef struct packed {
    logic [AW-1:0] head;
    logic [CW-1:0] count;
    logic [63:0]   first_unstable;
    logic          snap_held;
    logic [63:0]   snap_index;
    logic [63:0]   snap_term;
  } state_t;

  // Position of the request index relative to the unstable entries.
  typedef struct packed {
    logic          below;
    logic          at_or_below;
    logic          in_range;
    logic          d_eq;
    logic          d_lt;
    logic [CW-1:0] diff_lo;
    logic [AW-1:0] slot;
  } look_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [63:0]   data;
  } ring_wr_t;

endpackage
`default_nettype wire

// File: sv/consensus_unstable_log_table_unit.sv
// Top level of the unstable log table: term ring memory, state and sequencing.
//
//   Channel   Handshake              Payload              Direction
//   -------   --------------------   ------------------   ---------
//   item      start / busy           culog_pkg::req_t     in
//   result    done (one-cycle pulse) culog_pkg::rsp_t     out
//
// At the edge where an item is transferred, the index is placed against
// the unstable entries and the ring slot it maps to is read from the term
// memory, whose read data is registered. In the following cycle busy is
// high: the step logic combines the read term with the state registers,
// writes the ring back if the item appends, updates the state and registers
// the result, which is shown with done for one cycle.
// A new item may be transferred in that same cycle, but none while busy is
// high, so an item is finished before the next one is taken.
// Because a write always lands before the next read is issued, no forwarding
// is needed. Reset clears the control state at once; the ring has no clearing
// pass, since an entry is only ever read after it has been written.
// The receiver cannot stall results, so done never waits.
`default_nettype none
module consensus_unstable_log_table_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  culog_pkg::req_t   item,
  output logic              done,
  output culog_pkg::rsp_t   result
);
  import culog_pkg::*;

  // Term ring, one 64-bit term per slot.
  logic [63:0] ring [LOG_DEPTH];

  state_t   st;
  state_t   st_next;
  req_t     req_q;
  look_t    lk;
  look_t    lk_q;
  logic [63:0] rd_term;
  ring_wr_t wr;
  rsp_t     rsp;

  logic            accept;
  logic [63:0]     diff;
  logic [63:0]     count_wide;
  logic [AW+1:0]   slot_sum;

  assign accept = start && !busy;

  // Place the incoming index against the unstable entries. The slot sum
  // stays below twice the depth for every index that is actually used, so
  // one compare and subtract does the wrap.
  always_comb begin
    diff       = item.entry_index - st.first_unstable;
    count_wide = 64'(st.count);
    slot_sum   = (AW + 2)'(st.head) + (AW + 2)'(diff[AW:0]);
    lk.below       = item.entry_index < st.first_unstable;
    lk.at_or_below = lk.below || (diff == 64'd0);
    lk.d_eq        = diff == count_wide;
    lk.d_lt        = diff < count_wide;
    lk.in_range    = !lk.below && lk.d_lt;
    lk.diff_lo     = diff[CW-1:0];
    if (slot_sum >= (AW + 2)'(LOG_DEPTH)) begin
      lk.slot = AW'(slot_sum - (AW + 2)'(LOG_DEPTH));
    end else begin
      lk.slot = AW'(slot_sum);
    end
  end

  // Ring memory: written back in the execute cycle, read at the transfer.
  always_ff @(posedge clk) begin
    if (wr.en && busy) begin
      ring[wr.addr] <= wr.data;
    end
    if (accept) begin
      rd_term <= ring[lk.slot];
    end
  end

  culog_step u_step (
    .st      (st),
    .req     (req_q),
    .lk      (lk_q),
    .rd_term (rd_term),
    .st_next (st_next),
    .wr      (wr),
    .rsp     (rsp)
  );

  // Item capture and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= item;
      lk_q  <= lk;
    end
    if (busy) begin
      result <= rsp;
    end
  end

  // Control state and the log bookkeeping registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      st   <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      if (busy) begin
        st <= st_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/culog_step.sv
// Next-state, ring write-back and result logic of the unstable log table.
`default_nettype none
module culog_step (
  input  culog_pkg::state_t   st,
  input  culog_pkg::req_t     req,
  input  culog_pkg::look_t    lk,
  input  logic [63:0]         rd_term,
  output culog_pkg::state_t   st_next,
  output culog_pkg::ring_wr_t wr,
  output culog_pkg::rsp_t     rsp
);
  import culog_pkg::*;

  always_comb begin
    st_next = st;
    wr      = '0;
    rsp     = '0;
    wr.data = req.entry_term;
    case (req.mode)
      MODE_APPEND: begin
        if (lk.at_or_below) begin
          // The log restarts at the given index with this one entry.
          st_next.first_unstable = req.entry_index;
          st_next.head           = '0;
          st_next.count          = CW'(1);
          wr.en                  = 1'b1;
          wr.addr                = '0;
        end else if (lk.d_eq && (st.count == CW'(LOG_DEPTH))) begin
          rsp.status = STATUS_FULL;
        end else if (lk.d_eq || lk.d_lt) begin
          // Direct append, or truncate back to the index and append.
          st_next.count = lk.diff_lo + CW'(1);
          wr.en         = 1'b1;
          wr.addr       = lk.slot;
        end else begin
          rsp.status = STATUS_GAP;
        end
      end
      MODE_LOOKUP: begin
        if (lk.below) begin
          if (st.snap_held && (st.snap_index == req.entry_index)) begin
            rsp.found = 1'b1;
            rsp.term  = st.snap_term;
          end
        end else if (lk.in_range) begin
          rsp.found = 1'b1;
          rsp.term  = rd_term;
        end
      end
      MODE_STABLE_TO: begin
        if (lk.in_range && (rd_term == req.entry_term)) begin
          st_next.head = (lk.slot == AW'(LOG_DEPTH - 1)) ? '0 : lk.slot + AW'(1);
          st_next.count          = st.count - lk.diff_lo - CW'(1);
          st_next.first_unstable = req.entry_index + 64'd1;
        end
      end
      MODE_STABLE_SNAP: begin
        if (st.snap_held && (st.snap_index == req.entry_index)) begin
          st_next.snap_held = 1'b0;
        end
      end
      MODE_RESTORE_SNAP: begin
        st_next.first_unstable = req.entry_index + 64'd1;
        st_next.count          = '0;
        st_next.head           = '0;
        st_next.snap_held      = 1'b1;
        st_next.snap_index     = req.entry_index;
        st_next.snap_term      = req.entry_term;
      end
      default: begin
      end
    endcase

    rsp.first_valid = st_next.snap_held;
    rsp.first_index = st_next.snap_held ? st_next.snap_index + 64'd1 : 64'd0;
    if (st_next.count != '0) begin
      rsp.last_index = st_next.first_unstable + 64'(st_next.count) - 64'd1;
      rsp.last_valid = 1'b1;
    end else if (st_next.snap_held) begin
      rsp.last_index = st_next.snap_index;
      rsp.last_valid = 1'b1;
    end else begin
      rsp.last_index = 64'd0;
      rsp.last_valid = 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: sv/culog_checker.sv
// Port-level checker for the unstable log table, bound to the top level.
`default_nettype none
`include "consensus_unstable_log_table_unit_macros.svh"
module culog_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input culog_pkg::rsp_t result
);
  import culog_pkg::*;

  `CULOG_CHECK_NEXT(a_transfer_busy, clk, rst, start && !busy, busy && !done)
  `CULOG_CHECK_NEXT(a_busy_one_cycle, clk, rst, busy, !busy && done)
  `CULOG_CHECK_NEXT(a_no_stray_done, clk, rst, !busy, !done)
  `CULOG_CHECK_NOW(a_first_implies_last, clk, rst, done && result.first_valid, result.last_valid)
  `CULOG_CHECK_NOW(a_lookup_no_status, clk, rst, done && result.found, result.status == STATUS_OK)

endmodule

bind consensus_unstable_log_table_unit culog_checker u_culog_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire

// File: tb/sv/consensus_unstable_log_table_unit_test.sv
// Self-checking testbench of the unstable log table: queued commands against predicted results.
module consensus_unstable_log_table_unit_test;
  import culog_pkg::*;

  // The three unused mode codes report state and change nothing.
  localparam logic [2:0]  MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  MODE_SPARE_LAST  = 3'd7;
  localparam logic [63:0] ALL_ONES         = '1;
  localparam int unsigned RAND_ITEMS       = 800;
  // If no transfer happens before the quiet counter reaches QUIET_LIMIT,
  // the block is taken to have hung.
  localparam int unsigned QUIET_LIMIT      = 1000;
  localparam int unsigned TAIL_CYCLES      = 8;
  localparam int unsigned FILL_AFTER       = 300;

  // One queued command and the number of idle cycles the sender spends
  // before offering it.
  typedef struct {
    req_t        cmd;
    int unsigned gap;
  } pending_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t item  = '0;
  logic busy;
  logic done;
  rsp_t result;

  pending_t    pending_q[$];
  rsp_t        expected_results[$];
  int unsigned sent_n       = 0;
  int unsigned taken_n      = 0;
  int unsigned queued_n     = 0;
  int unsigned idle_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches   = 0;
  bit          calm         = 1'b0;

  // Predicted state of the table. The ring is only ever read at slots that
  // the predictor itself has written, so it needs no initial value.
  logic [63:0] ring_terms [LOG_DEPTH];
  int unsigned ring_start = 0;
  int unsigned live_count = 0;
  logic [63:0] base_index = '0;
  logic        held       = 1'b0;
  logic [63:0] held_index = '0;
  logic [63:0] held_term  = '0;

  consensus_unstable_log_table_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  function automatic int unsigned slot_for(int unsigned off);
    return (ring_start + off) % LOG_DEPTH;
  endfunction

  // Term known for a log index: an unstable entry, or the snapshot when the
  // index lies below the first unstable index. The term is zero on a miss.
  function automatic bit term_at(input logic [63:0] idx, output logic [63:0] t);
    t = '0;
    if (idx < base_index) begin
      if (held && held_index == idx) begin
        t = held_term;
        return 1'b1;
      end
      return 1'b0;
    end
    if (idx - base_index < 64'(live_count)) begin
      t = ring_terms[slot_for(32'(idx - base_index))];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Appending at or below the first unstable index restarts the log with the
  // one entry; inside the entries it truncates; right after the last entry
  // it extends, unless the ring is full; beyond that it leaves a gap.
  function automatic logic [1:0] append_entry(logic [63:0] idx, logic [63:0] t);
    logic [63:0] dist_v;
    if (idx <= base_index) begin
      base_index    = idx;
      ring_start    = 0;
      ring_terms[0] = t;
      live_count    = 1;
      return STATUS_OK;
    end
    dist_v = idx - base_index;
    if (dist_v == 64'(live_count)) begin
      if (live_count >= LOG_DEPTH) return STATUS_FULL;
    end else if (dist_v < 64'(live_count)) begin
      live_count = 32'(dist_v);
    end else begin
      return STATUS_GAP;
    end
    ring_terms[slot_for(live_count)] = t;
    live_count++;
    return STATUS_OK;
  endfunction

  function automatic rsp_t apply_command(req_t c);
    rsp_t        r;
    logic [63:0] t;
    bit          hit;
    int unsigned drop;
    r = '0;
    case (c.mode)
      MODE_APPEND: begin
        r.status = append_entry(c.entry_index, c.entry_term);
      end
      MODE_LOOKUP: begin
        r.found = term_at(c.entry_index, t);
        r.term  = t;
      end
      MODE_STABLE_TO: begin
        // A match against the snapshot sits below the first unstable index
        // and therefore drops nothing.
        hit = term_at(c.entry_index, t);
        if (hit && t == c.entry_term && c.entry_index >= base_index) begin
          drop       = 32'(c.entry_index - base_index) + 1;
          ring_start = slot_for(drop);
          live_count -= drop;
          base_index = c.entry_index + 64'd1;
        end
      end
      MODE_STABLE_SNAP: begin
        if (held && held_index == c.entry_index) held = 1'b0;
      end
      MODE_RESTORE_SNAP: begin
        base_index = c.entry_index + 64'd1;
        live_count = 0;
        ring_start = 0;
        held       = 1'b1;
        held_index = c.entry_index;
        held_term  = c.entry_term;
      end
      default: begin
      end
    endcase
    r.first_valid = held;
    r.first_index = held ? held_index + 64'd1 : '0;
    if (live_count != 0) begin
      r.last_index = base_index + 64'(live_count) - 64'd1;
      r.last_valid = 1'b1;
    end else if (held) begin
      r.last_index = held_index;
      r.last_valid = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers queued commands at the falling edge. A command stays on
  // the port until the rising edge that transfers it; the next one may
  // follow at once, so start is never dropped and raised in one step.
  // ---------------------------------------------------------------------

  always @(negedge clk) begin : feed_commands
    pending_t nxt;
    if (!rst && (!start || taken_n == sent_n)) begin
      if (pending_q.size() != 0 && idle_left < pending_q[0].gap) begin
        idle_left++;
        start <= 1'b0;
      end else if (pending_q.size() != 0) begin
        nxt = pending_q.pop_front();
        item  <= nxt.cmd;
        start <= 1'b1;
        idle_left = 0;
        sent_n++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: samples at the rising edge. A result is compared before the
  // command transferred at the same edge is predicted, since that result
  // always belongs to an older command.
  // ---------------------------------------------------------------------

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_results
    rsp_t want;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("term", want.term, result.term);
          check_field("found", 64'(want.found), 64'(result.found));
          check_field("status", 64'(want.status), 64'(result.status));
          check_field("first_index", want.first_index, result.first_index);
          check_field("first_valid", 64'(want.first_valid), 64'(result.first_valid));
          check_field("last_index", want.last_index, result.last_index);
          check_field("last_valid", 64'(want.last_valid), 64'(result.last_valid));
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_command(item));
        taken_n++;
      end
    end
  end

  // The run ends early when no transfer of either kind happens for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Base indexes cluster near zero, near the 32-bit boundary and near the
  // top of the index space, where sums wrap, or are drawn anywhere at random.
  function automatic logic [63:0] pick_base();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 1000));
      1: return ALL_ONES - 64'($urandom_range(0, 20));
      2: return 64'h0000_0000_ffff_fff0 + 64'($urandom_range(0, 31));
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] pick_term();
    case ($urandom_range(0, 2))
      0: return 64'($urandom_range(0, 3));
      1: return ALL_ONES - 64'($urandom_range(0, 3));
      default: return rand64();
    endcase
  endfunction

  task automatic queue_op(logic [2:0] m, logic [63:0] idx, logic [63:0] t);
    pending_t p;
    p.cmd.mode        = m;
    p.cmd.entry_index = idx;
    p.cmd.entry_term  = t;
    p.gap             = calm ? 0 : $urandom_range(0, 4);
    pending_q.push_back(p);
    queued_n++;
  endtask

  // Waits until every queued command has been transferred and answered, so
  // that the predicted state is the state of the block.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pending_q.size() != 0 || sent_n != taken_n || expected_results.size() != 0);
  endtask

  initial begin : stimulus
    int unsigned directed_n;
    int unsigned n;
    int unsigned k;
    logic [63:0] idx;
    logic [63:0] t;
    bit          filled;
    filled = 1'b0;

    // Directed opening, queued while reset is still high.
    queue_op(MODE_LOOKUP, '0, '0);                  // empty table
    queue_op(MODE_SPARE_FIRST, ALL_ONES, ALL_ONES);  // unused modes only report
    queue_op(MODE_SPARE_LAST, ALL_ONES, ALL_ONES);
    queue_op(MODE_APPEND, '0, ALL_ONES);             // restart at the first index
    queue_op(MODE_APPEND, 64'd1, '0);                // direct append
    queue_op(MODE_APPEND, 64'd3, 64'd9);             // gap, rejected
    queue_op(MODE_LOOKUP, 64'd1, ALL_ONES);
    queue_op(MODE_APPEND, 64'd1, 64'd5);             // truncate then append
    queue_op(MODE_STABLE_TO, '0, '0);                // term differs, no change
    queue_op(MODE_STABLE_TO, '0, ALL_ONES);          // drops the first entry
    queue_op(MODE_LOOKUP, '0, '0);                   // below, no snapshot
    queue_op(MODE_RESTORE_SNAP, ALL_ONES - 64'd1, ALL_ONES);
    queue_op(MODE_LOOKUP, ALL_ONES - 64'd1, '0);     // hits the snapshot
    queue_op(MODE_APPEND, ALL_ONES, 64'd2);          // at the first index
    queue_op(MODE_APPEND, '0, 64'd4);                // wrapped index restarts
    queue_op(MODE_RESTORE_SNAP, ALL_ONES, 64'd1);    // first unstable wraps to 0
    queue_op(MODE_LOOKUP, ALL_ONES, '0);             // no entries, snapshot above
    queue_op(MODE_STABLE_SNAP, 64'd5, '0);           // other index, kept
    queue_op(MODE_STABLE_SNAP, ALL_ONES, '0);        // snapshot dropped
    queue_op(MODE_LOOKUP, '0, '0);
    queue_op(MODE_RESTORE_SNAP, 64'd10, 64'd7);
    queue_op(MODE_STABLE_TO, 64'd10, 64'd7);         // matches the snapshot only
    queue_op(MODE_STABLE_SNAP, 64'd10, '0);
    queue_op(MODE_APPEND, 64'd11, 64'd3);
    directed_n = queued_n;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Random phases. Each one starts from a drained block, reads the
    // predicted state and builds a short sequence that fits it.
    while (queued_n < directed_n + RAND_ITEMS) begin
      wait_quiet();
      @(posedge clk);
      calm = ($urandom_range(0, 3) == 0);
      if (!filled && queued_n > FILL_AFTER) begin
        // Fill the ring to the brim, then push three more appends at it.
        filled = 1'b1;
        idx = 64'($urandom_range(0, 100000));
        queue_op(MODE_RESTORE_SNAP, idx, pick_term());
        for (k = 1; k <= LOG_DEPTH + 3; k++) queue_op(MODE_APPEND, idx + 64'(k), pick_term());
        queue_op(MODE_LOOKUP, idx + 64'd1, rand64());
        queue_op(MODE_LOOKUP, idx + 64'(LOG_DEPTH), rand64());
        continue;
      end
      case ($urandom_range(0, 7))
        0: begin
          // Restore, then a run of appends with lookups mixed in.
          idx = pick_base();
          queue_op(MODE_RESTORE_SNAP, idx, pick_term());
          n = $urandom_range(1, 12);
          for (k = 1; k <= n; k++) begin
            queue_op(MODE_APPEND, idx + 64'(k), pick_term());
            if ($urandom_range(0, 2) == 0)
              queue_op(MODE_LOOKUP, idx + 64'($urandom_range(0, k + 1)), rand64());
          end
        end
        1: begin
          // Extend the current log.
          idx = base_index + 64'(live_count);
          n = $urandom_range(1, 12);
          for (k = 0; k < n; k++) begin
            queue_op(MODE_APPEND, idx + 64'(k), pick_term());
            if ($urandom_range(0, 2) == 0)
              queue_op(MODE_LOOKUP, base_index + 64'($urandom_range(0, live_count + k + 1)),
                       rand64());
          end
        end
        2: begin
          // Overwrite: truncate inside the entries or restart at or below them.
          if (live_count == 0 || $urandom_range(0, 2) == 0)
            idx = base_index - 64'($urandom_range(0, 2));
          else
            idx = base_index + 64'($urandom_range(0, live_count - 1));
          queue_op(MODE_APPEND, idx, pick_term());
          n = $urandom_range(0, 3);
          for (k = 1; k <= n; k++) queue_op(MODE_APPEND, idx + 64'(k), pick_term());
          queue_op(MODE_LOOKUP, idx, rand64());
        end
        3: begin
          // Persist a prefix, mostly with the right term.
          if (live_count != 0) begin
            k = $urandom_range(0, live_count - 1);
            t = ring_terms[slot_for(k)];
            if ($urandom_range(0, 3) == 0) t = t ^ (64'd1 << $urandom_range(0, 63));
            queue_op(MODE_STABLE_TO, base_index + 64'(k), t);
            queue_op(MODE_LOOKUP, base_index + 64'(k), rand64());
            queue_op(MODE_LOOKUP, base_index + 64'(k) + 64'd1, rand64());
          end
          if (held && (live_count == 0 || $urandom_range(0, 2) == 0))
            queue_op(MODE_STABLE_TO, held_index, held_term);
        end
        4: begin
          // Drop the snapshot, mostly at its own index.
          queue_op(MODE_STABLE_SNAP, ($urandom_range(0, 3) == 0) ? rand64() : held_index,
                   rand64());
          queue_op(MODE_LOOKUP, held_index, rand64());
        end
        5: begin
          // Lookups around every edge of the known range.
          queue_op(MODE_LOOKUP, base_index - 64'd1, rand64());
          queue_op(MODE_LOOKUP, held_index, rand64());
          queue_op(MODE_LOOKUP, base_index + 64'(live_count), rand64());
          queue_op(MODE_LOOKUP, base_index + 64'($urandom_range(0, live_count)), rand64());
          queue_op(MODE_LOOKUP, rand64(), rand64());
        end
        default: begin
          // Noise: any mode, indexes near the log or anywhere.
          n = $urandom_range(3, 8);
          for (k = 0; k < n; k++) begin
            idx = ($urandom_range(0, 1) == 0) ? rand64()
                : base_index + 64'($urandom_range(0, live_count + 2)) - 64'd1;
            queue_op(3'($urandom_range(MODE_APPEND, MODE_SPARE_LAST)), idx, rand64());
          end
        end
      endcase
    end

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/culog_pkg.sv
sv/culog_step.sv
sv/consensus_unstable_log_table_unit.sv
sv/culog_checker.sv
tb/sv/consensus_unstable_log_table_unit_test.sv
